// File: design/ophs_pkg.sv
// Shared types, constants and codes for the operator pair history stack.
package ophs_pkg;

   // Stack depth and operator width.
   localparam int DEPTH   = 256;
   localparam int OP_BITS = 10;

   // Widths of the count and of the fixed request and response fields.
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int KIND_W   = 4;
   localparam int AMT_W    = 9;
   localparam int DOUT_W   = 9;
   localparam int STATUS_W = 2;
   localparam int WIDE_W   = (CNT_W > AMT_W) ? CNT_W : AMT_W;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH         = 4'd0,
      KIND_PEEK_TOP     = 4'd1,
      KIND_PEEK_SECOND  = 4'd2,
      KIND_POP          = 4'd3,
      KIND_DROP         = 4'd4,
      KIND_REPLACE_OP   = 4'd5,
      KIND_REPLACE_PAIR = 4'd6,
      KIND_CLEAR        = 4'd7,
      KIND_SET_ENABLE   = 4'd8
   } ophs_kind_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_IGNORED  = 2'd1,
      ST_OVERFLOW = 2'd2
   } ophs_status_type;

   // Stack modes; frozen behaves as disabled and cannot be left.
   typedef enum logic [1:0] {
      MODE_ENABLED  = 2'd0,
      MODE_DISABLED = 2'd1,
      MODE_FROZEN   = 2'd2
   } ophs_mode_type;

   // One stack entry.
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [OP_BITS-1:0] extra;
   } ophs_entry_type;

   // Request payload.
   typedef struct packed {
      logic [KIND_W-1:0]  req_type;
      logic [OP_BITS-1:0] op_code;
      logic [OP_BITS-1:0] op_extra;
      logic [AMT_W-1:0]   amount;
      logic               enable_flag;
   } ophs_request_type;

   // Response payload.
   typedef struct packed {
      logic                hit;
      logic [OP_BITS-1:0]  op_out;
      logic [OP_BITS-1:0]  extra_out;
      logic [STATUS_W-1:0] status;
      logic [DOUT_W-1:0]   depth_out;
   } ophs_response_type;

   // Command broadcast to the cell chain.
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic load_op;
      logic load_extra;
   } ophs_cell_cmd_type;

endpackage

// File: design/ophs_cell.sv
// One stack cell: holds an entry and moves it to a neighbor on push or pop.
module ophs_cell
   import ophs_pkg::*;
(
   input  logic              clock,
   input  ophs_cell_cmd_type cmd,
   input  ophs_entry_type    upper,
   input  ophs_entry_type    lower,
   output ophs_entry_type    data
);

   ophs_entry_type data_ff;
   ophs_entry_type data_in;

   // A push takes the entry above, a pop the entry below; loads patch in place.
   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         data_in = upper;
      end else if (cmd.shift_down) begin
         data_in = lower;
      end else begin
         if (cmd.load_op) begin
            data_in.op = upper.op;
         end
         if (cmd.load_extra) begin
            data_in.extra = upper.extra;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: design/ophs_ctrl.sv
// Request decoder, count and mode registers, drop sequencer and response register.
module ophs_ctrl
   import ophs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ophs_request_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ophs_response_type rsp_data,
   input  ophs_entry_type    top_entry,
   input  ophs_entry_type    second_entry,
   output ophs_entry_type    new_entry,
   output ophs_cell_cmd_type cell_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DROP = 2'b10
   } ophs_state_type;

   ophs_state_type    state_ff,     state_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   ophs_mode_type     mode_ff,      mode_in;
   logic [CNT_W-1:0]  drop_left_ff, drop_left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ophs_response_type rsp_ff,       rsp_in;

   logic              req_fire;
   logic              rsp_fire;
   logic              off;
   logic [WIDE_W-1:0] amt_wide;
   logic [WIDE_W-1:0] cnt_wide;
   logic [CNT_W-1:0]  drop_n;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign off       = (mode_ff != MODE_ENABLED);

   assign new_entry.op    = req_data.op_code;
   assign new_entry.extra = req_data.op_extra;

   // Drop length saturates at the current count.
   assign amt_wide = WIDE_W'(req_data.amount);
   assign cnt_wide = WIDE_W'(count_ff);
   assign drop_n   = (amt_wide >= cnt_wide) ? count_ff : CNT_W'(amt_wide);

   // Decode a request against the count, the mode and the two top cells.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      drop_left_in = drop_left_ff;
      cell_cmd     = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.status    = ST_IGNORED;
               unique case (ophs_kind_type'(req_data.req_type)) inside
                  KIND_PUSH: begin
                     if (!off) begin
                        if (count_ff >= CNT_W'(DEPTH)) begin
                           mode_in       = MODE_DISABLED;
                           rsp_in.status = ST_OVERFLOW;
                        end else begin
                           cell_cmd.shift_up = 1'b1;
                           count_in          = count_ff + 1'b1;
                           rsp_in.status     = ST_DONE;
                        end
                     end
                  end
                  KIND_PEEK_TOP, KIND_POP: begin
                     if (!off && count_ff != '0) begin
                        rsp_in.hit       = 1'b1;
                        rsp_in.op_out    = top_entry.op;
                        rsp_in.extra_out = top_entry.extra;
                        rsp_in.status    = ST_DONE;
                        if (ophs_kind_type'(req_data.req_type) == KIND_POP) begin
                           cell_cmd.shift_down = 1'b1;
                           count_in            = count_ff - 1'b1;
                        end
                     end
                  end
                  KIND_PEEK_SECOND: begin
                     if (!off && count_ff >= CNT_W'(2)) begin
                        rsp_in.hit       = 1'b1;
                        rsp_in.op_out    = second_entry.op;
                        rsp_in.extra_out = second_entry.extra;
                        rsp_in.status    = ST_DONE;
                     end
                  end
                  KIND_DROP: begin
                     if (!off && count_ff != '0) begin
                        count_in      = count_ff - drop_n;
                        rsp_in.status = ST_DONE;
                        // The first shift goes now, the rest one per cycle.
                        if (drop_n != '0) begin
                           cell_cmd.shift_down = 1'b1;
                           drop_left_in        = drop_n - 1'b1;
                           if (drop_n != CNT_W'(1)) begin
                              state_in = ST_DROP;
                           end
                        end
                     end
                  end
                  KIND_REPLACE_OP, KIND_REPLACE_PAIR: begin
                     if (!off && count_ff != '0) begin
                        cell_cmd.load_op = 1'b1;
                        cell_cmd.load_extra =
                           (ophs_kind_type'(req_data.req_type) == KIND_REPLACE_PAIR);
                        rsp_in.status = ST_DONE;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in      = '0;
                     mode_in       = MODE_FROZEN;
                     rsp_in.status = ST_DONE;
                  end
                  KIND_SET_ENABLE: begin
                     if (mode_ff != MODE_FROZEN) begin
                        mode_in       = req_data.enable_flag ? MODE_ENABLED : MODE_DISABLED;
                        rsp_in.status = ST_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.depth_out = DOUT_W'(count_in);
            end
         end
         ST_DROP: begin
            cell_cmd.shift_down = 1'b1;
            drop_left_in        = drop_left_ff - 1'b1;
            if (drop_left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= MODE_ENABLED;
         drop_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         drop_left_ff <= drop_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The count never exceeds the stack depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stack count above depth");

   // Once frozen, the mode stays frozen.
   a_frozen_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_FROZEN |=> mode_ff == MODE_FROZEN)
      else $error("frozen mode was left");

   // While a drop is shifting, no request is taken and cells shift down.
   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DROP |-> req_stall && cell_cmd.shift_down && drop_left_ff != '0)
      else $error("drop sequencing broken");

   // A returned entry always comes with done status.
   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hit |-> rsp_ff.status == ST_DONE)
      else $error("hit without done status");

endmodule

// File: design/operator_pair_history_stack_top.sv
// Top level of the operator pair history stack: controller and chain of cells.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall   ophs_request_type
//   rsp_      out        rsp_valid / rsp_stall   ophs_response_type
//
// A drop of N entries (N capped at the count) holds off further requests until
// the cell chain, shifting down one position per cycle, has moved N times.
// The response is registered and appears the cycle after the request.
// A new request is taken while the held response is being read out.
// Reset clears count, mode and handshake state; cell contents are left as is.
module operator_pair_history_stack_top
   import ophs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ophs_request_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ophs_response_type rsp_data
);

   ophs_entry_type    cell_q [DEPTH];
   ophs_entry_type    new_entry;
   ophs_cell_cmd_type cell_cmd;
   ophs_cell_cmd_type shift_cmd;

   ophs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .top_entry    (cell_q[0]),
      .second_entry (cell_q[1]),
      .new_entry    (new_entry),
      .cell_cmd     (cell_cmd)
   );

   // Only the top cell takes in-place loads; the rest just shift.
   always_comb begin
      shift_cmd            = cell_cmd;
      shift_cmd.load_op    = 1'b0;
      shift_cmd.load_extra = 1'b0;
   end

   // Cell 0 is the top of the stack.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         ophs_cell u_cell (
            .clock (clock),
            .cmd   (cell_cmd),
            .upper (new_entry),
            .lower (cell_q[i+1]),
            .data  (cell_q[i])
         );
      end else if (i == DEPTH - 1) begin : g_bottom
         ophs_cell u_cell (
            .clock (clock),
            .cmd   (shift_cmd),
            .upper (cell_q[i-1]),
            .lower (cell_q[i]),
            .data  (cell_q[i])
         );
      end else begin : g_mid
         ophs_cell u_cell (
            .clock (clock),
            .cmd   (shift_cmd),
            .upper (cell_q[i-1]),
            .lower (cell_q[i+1]),
            .data  (cell_q[i])
         );
      end
   end

endmodule

// File: bench/operator_pair_history_stack_top_tb.sv
// Self-checking testbench for the operator pair history stack top level.
`timescale 1ns / 100ps

module operator_pair_history_stack_top_tb;
   import ophs_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 850;
   localparam int FILL_AFTER   = 250;
   localparam int FILL_PUSHES  = DEPTH + 4;
   localparam int HOLD_CYCLES  = 64;
   localparam int HOLD_SPACING = 350;
   localparam int DRAIN_CYCLES = DEPTH + 16;
   localparam int CYCLE_LIMIT  = 1000000;

   // Request kinds the block does not know; they must be ignored.
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_FIRST = 4'd9;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_LAST  = 4'd15;

   localparam logic [OP_BITS-1:0] OP_MAX     = '1;
   localparam logic [AMT_W-1:0]   AMOUNT_MAX = '1;

   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_NOISE
   } request_mix_type;

   typedef struct {
      ophs_request_type req;
      bit               drain_first;
   } pending_request_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ophs_request_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ophs_response_type rsp_data;

   // Shadow copy of the stack.
   ophs_entry_type   stack_mem [DEPTH];
   logic [CNT_W-1:0] stack_count = '0;
   ophs_mode_type    stack_mode  = MODE_ENABLED;

   pending_request_type pending_requests [$];
   ophs_response_type   expected_responses [$];
   ophs_response_type   oldest_response;
   ophs_response_type   predicted_response;

   bit          req_taken = 1'b0;
   int          fail_count;
   int          accepted_count;
   int          compared_count;
   int          hit_count;
   int          overflow_count;
   int          ignored_count;
   int          peak_depth;
   int          burst_left;
   int          gap_left;
   int          hold_left;
   int          next_hold_at = 200;
   int          pattern_left;
   logic [15:0] stall_pattern;
   int          cycle_count;

   operator_pair_history_stack_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Applies one request to the shadow stack and returns the response it should give.
   function automatic ophs_response_type predict_stack_response(input ophs_request_type req);
      ophs_response_type rsp;
      logic              off;
      rsp        = '0;
      rsp.status = ST_IGNORED;
      off        = (stack_mode != MODE_ENABLED);
      case (req.req_type)
         KIND_PUSH: begin
            if (!off && stack_count >= DEPTH) begin
               // A push onto a full stack is lost and turns the stack off.
               stack_mode = MODE_DISABLED;
               rsp.status = ST_OVERFLOW;
            end else if (!off) begin
               stack_mem[stack_count].op    = req.op_code;
               stack_mem[stack_count].extra = req.op_extra;
               stack_count = stack_count + 1'b1;
               rsp.status  = ST_DONE;
            end
         end
         KIND_PEEK_TOP, KIND_POP: begin
            if (!off && stack_count != 0) begin
               rsp.hit       = 1'b1;
               rsp.op_out    = stack_mem[stack_count - 1].op;
               rsp.extra_out = stack_mem[stack_count - 1].extra;
               rsp.status    = ST_DONE;
               if (req.req_type == KIND_POP) begin
                  stack_count = stack_count - 1'b1;
               end
            end
         end
         KIND_PEEK_SECOND: begin
            if (!off && stack_count >= 2) begin
               rsp.hit       = 1'b1;
               rsp.op_out    = stack_mem[stack_count - 2].op;
               rsp.extra_out = stack_mem[stack_count - 2].extra;
               rsp.status    = ST_DONE;
            end
         end
         KIND_DROP: begin
            // The count saturates at zero rather than wrapping.
            if (!off && stack_count != 0) begin
               if (req.amount >= stack_count) begin
                  stack_count = '0;
               end else begin
                  stack_count = stack_count - req.amount;
               end
               rsp.status = ST_DONE;
            end
         end
         KIND_REPLACE_OP, KIND_REPLACE_PAIR: begin
            if (!off && stack_count != 0) begin
               stack_mem[stack_count - 1].op = req.op_code;
               if (req.req_type == KIND_REPLACE_PAIR) begin
                  stack_mem[stack_count - 1].extra = req.op_extra;
               end
               rsp.status = ST_DONE;
            end
         end
         KIND_CLEAR: begin
            stack_count = '0;
            stack_mode  = MODE_FROZEN;
            rsp.status  = ST_DONE;
         end
         KIND_SET_ENABLE: begin
            if (stack_mode != MODE_FROZEN) begin
               stack_mode = req.enable_flag ? MODE_ENABLED : MODE_DISABLED;
               rsp.status = ST_DONE;
            end
         end
         default: begin
         end
      endcase
      rsp.depth_out = stack_count;
      return rsp;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   function automatic ophs_request_type make_request(input logic [KIND_W-1:0] kind,
                                                     input logic [OP_BITS-1:0] op,
                                                     input logic [OP_BITS-1:0] extra,
                                                     input logic [AMT_W-1:0] amount,
                                                     input logic flag);
      ophs_request_type req;
      req.req_type    = kind;
      req.op_code     = op;
      req.op_extra    = extra;
      req.amount      = amount;
      req.enable_flag = flag;
      return req;
   endfunction

   task automatic queue_request(input ophs_request_type req, input bit drain_first);
      pending_request_type item;
      item.req         = req;
      item.drain_first = drain_first;
      pending_requests.push_back(item);
   endtask

   // Operator values lean toward the extremes now and then.
   function automatic logic [OP_BITS-1:0] random_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return OP_MAX;
         default: return OP_BITS'($urandom);
      endcase
   endfunction

   function automatic ophs_request_type random_request(input request_mix_type mix);
      ophs_request_type req;
      int unsigned      roll;
      req.op_code     = random_operand();
      req.op_extra    = ($urandom_range(0, 3) == 0) ? '0 : random_operand();
      req.amount      = AMT_W'($urandom);
      req.enable_flag = 1'($urandom);
      roll            = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (roll < 55)      req.req_type = KIND_PUSH;
            else if (roll < 65) req.req_type = KIND_PEEK_TOP;
            else if (roll < 72) req.req_type = KIND_PEEK_SECOND;
            else if (roll < 80) req.req_type = KIND_REPLACE_OP;
            else if (roll < 87) req.req_type = KIND_REPLACE_PAIR;
            else if (roll < 95) req.req_type = KIND_POP;
            else if (roll < 98) req.req_type = KIND_DROP;
            else                req.req_type = KIND_SET_ENABLE;
         end
         MIX_SHRINK: begin
            if (roll < 15)      req.req_type = KIND_PUSH;
            else if (roll < 27) req.req_type = KIND_PEEK_TOP;
            else if (roll < 35) req.req_type = KIND_PEEK_SECOND;
            else if (roll < 65) req.req_type = KIND_POP;
            else if (roll < 85) req.req_type = KIND_DROP;
            else if (roll < 90) req.req_type = KIND_REPLACE_OP;
            else if (roll < 95) req.req_type = KIND_REPLACE_PAIR;
            else                req.req_type = KIND_SET_ENABLE;
         end
         default: begin
            // Any kind at all, but a clear would freeze the stack for good.
            req.req_type = KIND_W'($urandom_range(0, 15));
            if (req.req_type == KIND_CLEAR) begin
               req.req_type = KIND_SET_ENABLE;
            end
         end
      endcase
      // Most drops are short, so the shift-down stays cheap.
      if (req.req_type == KIND_DROP && $urandom_range(0, 9) != 0) begin
         req.amount = AMT_W'($urandom_range(0, 5));
      end
      if (req.req_type == KIND_SET_ENABLE && mix != MIX_NOISE) begin
         req.enable_flag = 1'b1;
      end
      return req;
   endfunction

   // Driver: offers queued requests in bursts, holding each until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_responses.size() != 0)) begin
            req_data  <= pending_requests[0].req;
            req_valid <= 1'b1;
            void'(pending_requests.pop_front());
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 7) == 0) begin
               // A long stretch without gaps.
               burst_left = $urandom_range(40, 100);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls on a rotating pattern, with a long hold-off now and then.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (accepted_count >= next_hold_at) begin
         hold_left    = HOLD_CYCLES - 1;
         next_hold_at = next_hold_at + HOLD_SPACING;
         rsp_stall   <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: stall_pattern = '0;
               1: stall_pattern = 16'($urandom & $urandom);
               2: stall_pattern = 16'($urandom);
               default: stall_pattern = 16'($urandom | $urandom);
            endcase
         end
         pattern_left--;
         rsp_stall    <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // Monitor: checks each response against the oldest prediction, then predicts new requests.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("response arrived with no request outstanding");
               fail_count++;
            end else begin
               oldest_response = expected_responses.pop_front();
               check_field("hit", oldest_response.hit, rsp_data.hit);
               check_field("op_out", oldest_response.op_out, rsp_data.op_out);
               check_field("extra_out", oldest_response.extra_out, rsp_data.extra_out);
               check_field("status", oldest_response.status, rsp_data.status);
               check_field("depth_out", oldest_response.depth_out, rsp_data.depth_out);
               compared_count++;
            end
         end
         if (req_valid && !req_stall) begin
            predicted_response = predict_stack_response(req_data);
            expected_responses.push_back(predicted_response);
            accepted_count++;
            hit_count += predicted_response.hit;
            if (predicted_response.status == ST_OVERFLOW) overflow_count++;
            if (predicted_response.status == ST_IGNORED) ignored_count++;
            if (predicted_response.depth_out > peak_depth) peak_depth = predicted_response.depth_out;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      request_mix_type mix;
      int              random_items;
      int              segment_len;
      bit              fill_done;

      // Peeks, pop, drop and op replace on an empty stack are all too shallow.
      queue_request(make_request(KIND_PEEK_TOP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PEEK_SECOND, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_POP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_DROP, '0, '0, 9'd5, 1'b0), 1'b0);
      queue_request(make_request(KIND_REPLACE_OP, 10'd7, '0, '0, 1'b0), 1'b0);
      // Peeks, replaces and pops around a depth of one and two.
      queue_request(make_request(KIND_PUSH, OP_MAX, OP_MAX, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PEEK_SECOND, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PUSH, 10'h155, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PEEK_SECOND, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PEEK_TOP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_REPLACE_OP, 10'h2AA, OP_MAX, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_REPLACE_PAIR, '0, 10'h3C3, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_POP, '0, '0, '0, 1'b0), 1'b0);
      // A zero drop, then a drop far past the count.
      queue_request(make_request(KIND_PUSH, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_DROP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_DROP, '0, '0, AMOUNT_MAX, 1'b0), 1'b0);
      // Disabled stack ignores work until enabled again.
      queue_request(make_request(KIND_SET_ENABLE, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PUSH, 10'd1, 10'd2, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_POP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_SET_ENABLE, OP_MAX, OP_MAX, AMOUNT_MAX, 1'b1), 1'b0);
      // Unknown kinds.
      queue_request(make_request(KIND_UNKNOWN_FIRST, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_UNKNOWN_LAST, OP_MAX, OP_MAX, AMOUNT_MAX, 1'b1), 1'b0);
      queue_request(make_request(KIND_PUSH, 10'd512, 10'd1, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PUSH, 10'd3, 10'd4, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_DROP, '0, '0, 9'd2, 1'b0), 1'b0);

      // Random segments of growing, shrinking and noisy traffic, with one fill to overflow.
      random_items = 0;
      fill_done    = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         if (!fill_done && random_items >= FILL_AFTER) begin
            queue_request(make_request(KIND_SET_ENABLE, '0, '0, '0, 1'b1), 1'b1);
            for (int i = 0; i < FILL_PUSHES; i++) begin
               queue_request(make_request(KIND_PUSH, random_operand(), random_operand(),
                                          AMT_W'($urandom), 1'($urandom)), 1'b0);
            end
            random_items += FILL_PUSHES + 1;
            fill_done     = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mix = MIX_GROW;
            4, 5, 6, 7: mix = MIX_SHRINK;
            default:    mix = MIX_NOISE;
         endcase
         if (mix == MIX_NOISE) begin
            segment_len = $urandom_range(4, 15);
         end else begin
            // Re-enable first, so an earlier overflow or disable does not stall the segment.
            segment_len = $urandom_range(10, 60);
            queue_request(make_request(KIND_SET_ENABLE, random_operand(), random_operand(),
                                       AMT_W'($urandom), 1'b1), $urandom_range(0, 4) == 0);
            random_items++;
         end
         for (int i = 0; i < segment_len; i++) begin
            queue_request(random_request(mix), 1'b0);
         end
         random_items += segment_len;
      end

      // Clear freezes the stack; after it only a further clear is done, all else is ignored for good.
      queue_request(make_request(KIND_SET_ENABLE, '0, '0, '0, 1'b1), 1'b1);
      queue_request(make_request(KIND_PUSH, OP_MAX, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_CLEAR, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PUSH, 10'd9, 10'd9, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_PEEK_TOP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_SET_ENABLE, '0, '0, '0, 1'b1), 1'b0);
      queue_request(make_request(KIND_SET_ENABLE, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_CLEAR, OP_MAX, OP_MAX, AMOUNT_MAX, 1'b1), 1'b0);
      queue_request(make_request(KIND_POP, '0, '0, '0, 1'b0), 1'b0);
      queue_request(make_request(KIND_DROP, '0, '0, 9'd3, 1'b0), 1'b0);
      queue_request(make_request(KIND_UNKNOWN_LAST, '0, '0, '0, 1'b0), 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to go in and every response to come back.
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0) begin
         $error("%0d responses never arrived", expected_responses.size());
         fail_count++;
      end

      $display("Covered %0d requests, %0d responses compared: %0d hits, %0d overflows,",
               accepted_count, compared_count, hit_count, overflow_count);
      $display("%0d ignored, peak depth %0d, %0d mismatches.",
               ignored_count, peak_depth, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/ophs_pkg.sv
design/ophs_cell.sv
design/ophs_ctrl.sv
design/operator_pair_history_stack_top.sv
bench/operator_pair_history_stack_top_tb.sv
